// File: hw/rtl/apq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Request and result payloads, entry layout, status and function codes and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

  // Capacity of the queue and derived widths
  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 4;

  // Function codes
  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // One stored queue entry
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       enq_write;
    logic       scan_start;
    logic       scan_step;
    logic       shift_start;
    logic       shift_step;
    logic       count_dec;
    logic       finish;
    logic       fin_sel;
    logic [1:0] fin_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       stream_idle;
  } dp_stat_t;

endpackage

// File: hw/rtl/apq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/apq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_dp: array priority queue datapath
// Entry RAM, entry count, streaming read pointer shared by the selection scan
// and the shift-down pass, best-entry tracking and the result register.
// ----------------------------------------------------------------------------
module apq_dp (
  input  logic              clk,
  input  logic              rst,
  input  apq_pkg::req_t     req,
  input  apq_pkg::dp_cmd_t  cmd,
  output apq_pkg::dp_stat_t stat,
  output apq_pkg::rsp_t     rsp
);
  import apq_pkg::*;

  req_t             req_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] dptr;
  logic [CNT_W-1:0] shift_dst;
  logic             dvalid;
  logic             rd_ok;
  logic             stream_step;
  logic             better;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;
  entry_t           rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  // Count update
  always_comb begin
    count_next = count;
    if (cmd.enq_write) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.count_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign rd_ok       = (ptr < count);
  assign stream_step = cmd.scan_step | cmd.shift_step;
  assign rd_entry    = entry_t'(rd_data);
  assign shift_dst   = dptr - CNT_W'(1);

  // Higher priority wins, then larger value; ties keep the earlier entry
  assign better = (rd_entry.prio > best.prio) ||
                  ((rd_entry.prio == best.prio) && (rd_entry.value > best.value));

  // RAM write: append on enqueue, move entry down one slot during the shift
  assign ram_we    = cmd.enq_write | (cmd.shift_step & dvalid);
  assign ram_waddr = cmd.enq_write ? count[IDX_W-1:0] : shift_dst[IDX_W-1:0];
  assign ram_wdata = cmd.enq_write ? {req_q.item_value, req_q.item_priority} : rd_data;

  apq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr[IDX_W-1:0]),
    .rdata(rd_data)
  );

  // Control state: count and stream pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ptr    <= '0;
      dvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.scan_start) begin
        ptr    <= '0;
        dvalid <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr    <= CNT_W'(best_idx) + CNT_W'(1);
        dvalid <= 1'b0;
      end else if (stream_step) begin
        if (rd_ok) begin
          ptr <= ptr + CNT_W'(1);
        end
        dvalid <= rd_ok;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (stream_step) begin
      dptr <= ptr;
    end
    if (cmd.scan_step && dvalid && ((dptr == '0) || better)) begin
      best     <= rd_entry;
      best_idx <= dptr[IDX_W-1:0];
    end
    if (cmd.finish) begin
      rsp.status       <= cmd.fin_status;
      rsp.out_value    <= cmd.fin_sel ? best.value : '0;
      rsp.out_priority <= cmd.fin_sel ? best.prio : '0;
      rsp.occupancy    <= OCC_W'(count_next);
    end
  end

  // Status to controller
  assign stat.func        = req_q.func;
  assign stat.empty       = (count == '0);
  assign stat.full        = (count == CNT_W'(ENTRIES));
  assign stat.stream_idle = !rd_ok && !dvalid;

`ifndef SYNTH
  a_enq_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_write |-> (count < CNT_W'(ENTRIES)))
    else $error("enqueue write issued with a full queue");

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (cmd.fin_status == ST_EMPTY)) |-> (count == '0))
    else $error("empty status reported with entries held");

  a_shift_dst: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_step && dvalid) |-> (dptr != '0))
    else $error("shift write below entry zero");
`endif

endmodule

// File: hw/rtl/apq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ctrl: array priority queue controller
// Sequences decode, selection scan and shift-down, and strobes the result.
// ----------------------------------------------------------------------------
module apq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  apq_pkg::dp_stat_t stat,
  output apq_pkg::dp_cmd_t  cmd
);
  import apq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.func)
          FUNC_ENQ: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.enq_write  = 1'b1;
              cmd.fin_status = ST_OK;
            end
          end
          FUNC_DEQ, FUNC_PEEK: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            // unused code: no operation, plain ok result
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.stream_idle) begin
          if (stat.func == FUNC_PEEK) begin
            cmd.finish     = 1'b1;
            cmd.fin_sel    = 1'b1;
            cmd.fin_status = ST_OK;
            state_next     = S_IDLE;
          end else begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.stream_idle) begin
          cmd.count_dec  = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_sel    = 1'b1;
          cmd.fin_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");
`endif

endmodule

// File: hw/rtl/array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue: unsorted-array priority queue, top level
// Holds up to ENTRIES value/priority pairs; enqueue appends, peek selects the
// highest priority (then larger value, then earliest), dequeue also removes it.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------
//   request   | start & !busy         | req : func, item_value, item_priority
//   result    | done (one cycle)      | rsp : status, out_value, out_priority,
//             |                       |       occupancy
//
// Enqueue and empty/full cases: result strobed from the decode state.
// Peek adds a selection scan of all N entries; dequeue adds a shift-down of the
// entries above the removed one, both via the single read port of the entry RAM.
// busy drops in the strobe cycle, so the next transaction may be accepted there.
// rst is synchronous; it empties the queue, entry storage is left as is.
// The receiver cannot stall: each result is valid only while done is high.
// ----------------------------------------------------------------------------
module array_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  apq_pkg::req_t req,
  output logic          done,
  output apq_pkg::rsp_t rsp
);
  import apq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  apq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .stat (stat),
    .cmd  (cmd)
  );

  apq_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule
